>>> rtl/vsvm_pkg.sv
// Shared types and constants for the velocity magnitude slice block.
// Used by vsvm_front, vsvm_queue, vsvm_root and the top level.
package vsvm_pkg;

  localparam int unsigned MAX_DIM_DEF = 256;
  localparam int unsigned SIZE_W      = 9;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned VEL_W       = 16;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned POS_CFG_W   = 8;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X    = 3'd0,
    REG_SIZE_Y    = 3'd1,
    REG_SIZE_Z    = 3'd2,
    REG_PLANE_MODE = 3'd3,
    REG_PLANE_POS = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PLANE_XY = 2'd0,
    PLANE_XZ = 2'd1,
    PLANE_YZ = 2'd2
  } plane_mode_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_ROOT,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
  } in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [INDEX_W-1:0] plane_index;
    logic               plane_last;
  } out_t;

  typedef struct packed {
    logic [VEL_W-1:0]   mag_x;
    logic [VEL_W-1:0]   mag_y;
    logic [VEL_W-1:0]   mag_z;
    logic [INDEX_W-1:0] plane_index;
    logic               plane_last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> rtl/volume_slice_velocity_magnitude.sv
// Off-plane points are taken one per cycle while the queue has room; plane points
// queue for the root unit. With the back end idle, a plane point is loaded from the
// queue, squared and summed on the shared squarer, then passed through the bit-serial
// root, whose last step writes the output register. The root unit takes no new plane
// point until the result of the last one has been taken.
// Reset clears counters and queue, sizes 1, XY, 0.
// Top level; instantiates vsvm_front, vsvm_queue and vsvm_root from vsvm_pkg.
module volume_slice_velocity_magnitude #(
  parameter int unsigned MAX_DIM = vsvm_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vsvm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vsvm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  vsvm_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output vsvm_pkg::out_t                  out_data_o
);

  vsvm_pkg::queue_status_t queue_status;
  vsvm_pkg::job_t          push_data, pop_data;
  logic                    push, pop;

  vsvm_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .queue_status_i(queue_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  vsvm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .status_o   (queue_status)
  );

  vsvm_root u_root (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_status_i(queue_status),
    .job_i         (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

>>> rtl/vsvm_front.sv
// Front end: configuration registers, grid position counters and plane match.
// Pushes absolute components and the plane index of matching points.
// Depends on vsvm_pkg.
module vsvm_front #(
  parameter int unsigned MAX_DIM = vsvm_pkg::MAX_DIM_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vsvm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [vsvm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  vsvm_pkg::in_t                    in_data_i,
  input  vsvm_pkg::queue_status_t          queue_status_i,
  output logic                             push_o,
  output vsvm_pkg::job_t                   push_data_o
);

  localparam int unsigned PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned EW = $clog2(MAX_DIM + 1);
  localparam int unsigned SW = vsvm_pkg::SIZE_W;
  localparam int unsigned CW = ((EW > SW) ? EW : SW) + 1;
  localparam int unsigned MW = 2 * CW;

  typedef logic [CW-1:0] coord_t;
  typedef logic [MW-1:0] wide_t;

  logic [SW-1:0]                   size_x_q, size_y_q, size_z_q;
  logic [1:0]                      plane_mode_q;
  logic [vsvm_pkg::POS_CFG_W-1:0]  plane_pos_q;
  logic [PW-1:0]                   pos_x_q, pos_x_d;
  logic [PW-1:0]                   pos_y_q, pos_y_d;
  logic [PW-1:0]                   pos_z_q, pos_z_d;

  logic   accept, size_wr, hit, last;
  coord_t sx, sy, sz, px, py, pz, pp;
  coord_t col, row, rowlen, rowsz;
  wide_t  idx_sum;

  function automatic coord_t eff_size(input logic [SW-1:0] s);
    coord_t v;
    v = coord_t'(s);
    if (v == coord_t'(0)) begin
      v = coord_t'(1);
    end else if (v > coord_t'(MAX_DIM)) begin
      v = coord_t'(MAX_DIM);
    end
    return v;
  endfunction

  function automatic logic [vsvm_pkg::VEL_W-1:0] abs_vel(
    input logic signed [vsvm_pkg::VEL_W-1:0] v
  );
    logic [vsvm_pkg::VEL_W-1:0] r;
    r = v[vsvm_pkg::VEL_W-1] ? vsvm_pkg::VEL_W'(-v) : vsvm_pkg::VEL_W'(v);
    return r;
  endfunction

  assign in_ready_o = !queue_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    size_wr = 1'b0;
    if (cfg_we_i) begin
      unique case (vsvm_pkg::cfg_reg_e'(cfg_index_i))
        vsvm_pkg::REG_SIZE_X,
        vsvm_pkg::REG_SIZE_Y,
        vsvm_pkg::REG_SIZE_Z: size_wr = 1'b1;
        default:              size_wr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q     <= SW'(1);
      size_y_q     <= SW'(1);
      size_z_q     <= SW'(1);
      plane_mode_q <= vsvm_pkg::PLANE_XY;
      plane_pos_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (vsvm_pkg::cfg_reg_e'(cfg_index_i))
        vsvm_pkg::REG_SIZE_X:     size_x_q     <= cfg_data_i;
        vsvm_pkg::REG_SIZE_Y:     size_y_q     <= cfg_data_i;
        vsvm_pkg::REG_SIZE_Z:     size_z_q     <= cfg_data_i;
        vsvm_pkg::REG_PLANE_MODE: plane_mode_q <= cfg_data_i[1:0];
        vsvm_pkg::REG_PLANE_POS:  plane_pos_q  <= cfg_data_i[vsvm_pkg::POS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sx = eff_size(size_x_q);
    sy = eff_size(size_y_q);
    sz = eff_size(size_z_q);
    px = coord_t'(pos_x_q);
    py = coord_t'(pos_y_q);
    pz = coord_t'(pos_z_q);
    pp = coord_t'(plane_pos_q);
  end

  // advance raster position, clear on size rewrite
  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (size_wr) begin
      pos_x_d = '0;
      pos_y_d = '0;
      pos_z_d = '0;
    end else if (accept) begin
      if (px + coord_t'(1) >= sx) begin
        pos_x_d = '0;
        if (py + coord_t'(1) >= sy) begin
          pos_y_d = '0;
          pos_z_d = (pz + coord_t'(1) >= sz) ? '0 : PW'(pz + coord_t'(1));
        end else begin
          pos_y_d = PW'(py + coord_t'(1));
        end
      end else begin
        pos_x_d = PW'(px + coord_t'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

  always_comb begin
    hit    = 1'b0;
    col    = px;
    row    = py;
    rowlen = sx;
    rowsz  = sy;
    unique case (plane_mode_q)
      vsvm_pkg::PLANE_XY: begin
        hit = (pz == pp) && (pp < sz);
      end
      vsvm_pkg::PLANE_XZ: begin
        hit   = (py == pp) && (pp < sy);
        row   = pz;
        rowsz = sz;
      end
      vsvm_pkg::PLANE_YZ: begin
        hit    = (px == pp) && (pp < sx);
        col    = py;
        row    = pz;
        rowlen = sy;
        rowsz  = sz;
      end
      default: hit = 1'b0;
    endcase
    last    = (col == rowlen - coord_t'(1)) && (row == rowsz - coord_t'(1));
    idx_sum = wide_t'(rowlen) * wide_t'(row) + wide_t'(col);
  end

  assign push_o                  = accept && hit;
  assign push_data_o.mag_x       = abs_vel(in_data_i.vel_x);
  assign push_data_o.mag_y       = abs_vel(in_data_i.vel_y);
  assign push_data_o.mag_z       = abs_vel(in_data_i.vel_z);
  assign push_data_o.plane_index = idx_sum[vsvm_pkg::INDEX_W-1:0];
  assign push_data_o.plane_last  = last;

endmodule

>>> rtl/vsvm_queue.sv
// Short register queue between the front end and the square root unit.
// Depends on vsvm_pkg.
module vsvm_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  vsvm_pkg::job_t          push_data_i,
  input  logic                    pop_i,
  output vsvm_pkg::job_t          pop_data_o,
  output vsvm_pkg::queue_status_t status_o
);

  localparam int unsigned DEPTH = vsvm_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  vsvm_pkg::job_t entry_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AW:0]    count_q, count_d;
  logic           do_push, do_pop;

  assign status_o.full  = (count_q == (AW+1)'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/vsvm_root.sv
// Back end: sum of squares through one shared squarer, then a digit-by-digit
// square root, one result bit per cycle, into the output register.
// Depends on vsvm_pkg.
module vsvm_root (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vsvm_pkg::queue_status_t queue_status_i,
  input  vsvm_pkg::job_t          job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output vsvm_pkg::out_t          out_data_o
);

  localparam int unsigned RW     = vsvm_pkg::SPEED_W;
  localparam int unsigned SUM_W  = 2 * RW;
  localparam int unsigned REM_W  = RW + 3;
  localparam int unsigned STEP_W = $clog2(RW);
  localparam int unsigned VW     = vsvm_pkg::VEL_W;

  vsvm_pkg::back_state_e state_q, state_d;
  logic [STEP_W-1:0]     step_q, step_d;
  vsvm_pkg::job_t        job_q, job_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [SUM_W-1:0]      rad_q, rad_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [RW-1:0]         root_q, root_d;
  vsvm_pkg::out_t        out_q, out_d;

  logic [VW-1:0]    sq_op;
  logic [SUM_W-1:0] sq_res;
  logic [REM_W-1:0] rem_shift, trial;

  always_comb begin
    case (step_q[1:0])
      2'd0:    sq_op = job_q.mag_x;
      2'd1:    sq_op = job_q.mag_y;
      default: sq_op = job_q.mag_z;
    endcase
    sq_res    = SUM_W'(sq_op) * SUM_W'(sq_op);
    rem_shift = {rem_q[REM_W-3:0], rad_q[SUM_W-1 -: 2]};
    trial     = {1'b0, root_q, 2'b01};
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    job_d   = job_q;
    sum_d   = sum_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    out_d   = out_q;
    pop_o   = 1'b0;
    unique case (state_q)
      vsvm_pkg::BK_IDLE: begin
        if (!queue_status_i.empty) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          sum_d   = '0;
          step_d  = '0;
          state_d = vsvm_pkg::BK_SQUARE;
        end
      end
      vsvm_pkg::BK_SQUARE: begin
        sum_d  = sum_q + sq_res;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(2)) begin
          rad_d   = sum_q + sq_res;
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = vsvm_pkg::BK_ROOT;
        end
      end
      vsvm_pkg::BK_ROOT: begin
        rad_d = rad_q << 2;
        if (rem_shift >= trial) begin
          rem_d  = rem_shift - trial;
          root_d = {root_q[RW-2:0], 1'b1};
        end else begin
          rem_d  = rem_shift;
          root_d = {root_q[RW-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(RW - 1)) begin
          out_d.speed       = root_d;
          out_d.plane_index = job_q.plane_index;
          out_d.plane_last  = job_q.plane_last;
          state_d           = vsvm_pkg::BK_DONE;
        end
      end
      vsvm_pkg::BK_DONE: begin
        if (out_ready_i) begin
          state_d = vsvm_pkg::BK_IDLE;
        end
      end
      default: state_d = vsvm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsvm_pkg::BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    sum_q  <= sum_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    out_q  <= out_d;
  end

  assign out_valid_o = (state_q == vsvm_pkg::BK_DONE);
  assign out_data_o  = out_q;

endmodule
